// ===== rtl/bth_pkg.sv =====
package bth_pkg;

	localparam int BYTE_W = 30;
	localparam int SIZE_W = 29;
	localparam int TAG_W = 32;
	localparam int ALLOC_POS = 29;
	localparam logic [BYTE_W-1:0] TAG_BYTES = BYTE_W'(8);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	localparam logic [1:0] STATUS_ALLOC = 2'd0;
	localparam logic [1:0] STATUS_NOFIT = 2'd1;
	localparam logic [1:0] STATUS_FREED = 2'd2;

	typedef struct packed {
		logic operation;
		logic [12:0] request_bytes;
		logic [11:0] block_address;
	} request_t;

	typedef struct packed {
		logic [11:0] payload_address;
		logic [1:0] status;
	} result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_A_START,
		ST_A_WALK,
		ST_A_SPLIT_H,
		ST_A_SPLIT_F,
		ST_F_START,
		ST_F_HDR,
		ST_F_NEXT,
		ST_F_PREV_RD,
		ST_F_PREV,
		ST_SET_H,
		ST_SET_F
	} state_t;

	typedef enum logic [1:0] {
		RD_ZERO,
		RD_NEXT,
		RD_HDR,
		RD_PREV
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_CLEAR,
		WR_SPLIT_H,
		WR_SPLIT_F,
		WR_SET_H,
		WR_SET_F
	} wr_sel_t;

	typedef struct packed {
		logic latch;
		logic a_init;
		logic walk_step;
		logic fit_take;
		logic load_h;
		logic hdr_load;
		logic merge_next;
		logic merge_prev;
		logic finish;
		logic [1:0] fin_status;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic op_free;
		logic free_bad;
		logic blk_ok;
		logic fits;
		logic split;
		logic next_end;
		logic next_ok;
		logic prev_ok;
		logic h_zero;
	} dp_status_t;

	function automatic logic [TAG_W-1:0] tag_make(input logic [BYTE_W-1:0] size,
			input logic used);
		return {2'b00, used, size[SIZE_W-1:0]};
	endfunction

endpackage

// ===== rtl/bth_ram.sv =====
module bth_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/bth_ctrl.sv =====
module bth_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic operation,
	input bth_pkg::dp_status_t stat,
	output bth_pkg::cmd_t cmd,
	output logic busy
);

	import bth_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.rd_sel = RD_ZERO;
		cmd.wr_sel = WR_NONE;
		cmd.fin_status = STATUS_FREED;
		busy = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.wr_sel = WR_CLEAR;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.latch = 1'b1;
					state_d = (operation == OP_FREE) ? ST_F_START : ST_A_START;
				end
			end
			ST_A_START: begin
				cmd.a_init = 1'b1;
				cmd.rd_sel = RD_ZERO;
				state_d = ST_A_WALK;
			end
			ST_A_WALK: begin
				if (!stat.blk_ok) begin
					cmd.finish = 1'b1;
					cmd.fin_status = STATUS_NOFIT;
					state_d = ST_IDLE;
				end else if (stat.fits) begin
					cmd.fit_take = 1'b1;
					state_d = stat.split ? ST_A_SPLIT_H : ST_SET_H;
				end else if (stat.next_end) begin
					cmd.finish = 1'b1;
					cmd.fin_status = STATUS_NOFIT;
					state_d = ST_IDLE;
				end else begin
					cmd.walk_step = 1'b1;
					cmd.rd_sel = RD_NEXT;
				end
			end
			ST_A_SPLIT_H: begin
				cmd.wr_sel = WR_SPLIT_H;
				state_d = ST_A_SPLIT_F;
			end
			ST_A_SPLIT_F: begin
				cmd.wr_sel = WR_SPLIT_F;
				state_d = ST_SET_H;
			end
			ST_F_START: begin
				if (stat.free_bad) begin
					cmd.finish = 1'b1;
					cmd.fin_status = STATUS_FREED;
					state_d = ST_IDLE;
				end else begin
					cmd.load_h = 1'b1;
					cmd.rd_sel = RD_HDR;
					state_d = ST_F_HDR;
				end
			end
			ST_F_HDR: begin
				if (!stat.blk_ok) begin
					cmd.finish = 1'b1;
					cmd.fin_status = STATUS_FREED;
					state_d = ST_IDLE;
				end else begin
					cmd.hdr_load = 1'b1;
					if (stat.next_end) begin
						state_d = ST_F_PREV_RD;
					end else begin
						cmd.rd_sel = RD_NEXT;
						state_d = ST_F_NEXT;
					end
				end
			end
			ST_F_NEXT: begin
				cmd.merge_next = stat.next_ok;
				state_d = ST_F_PREV_RD;
			end
			ST_F_PREV_RD: begin
				if (stat.h_zero) begin
					state_d = ST_SET_H;
				end else begin
					cmd.rd_sel = RD_PREV;
					state_d = ST_F_PREV;
				end
			end
			ST_F_PREV: begin
				cmd.merge_prev = stat.prev_ok;
				state_d = ST_SET_H;
			end
			ST_SET_H: begin
				cmd.wr_sel = WR_SET_H;
				state_d = ST_SET_F;
			end
			ST_SET_F: begin
				cmd.wr_sel = WR_SET_F;
				cmd.finish = 1'b1;
				cmd.fin_status = stat.op_free ? STATUS_FREED : STATUS_ALLOC;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/bth_datapath.sv =====
module bth_datapath #(
	parameter int HEAP_WORDS = 1024
) (
	input logic clk,
	input logic arst_n,
	input bth_pkg::request_t request,
	input bth_pkg::cmd_t cmd,
	output bth_pkg::dp_status_t stat,
	output bth_pkg::result_t result,
	output logic done
);

	import bth_pkg::*;

	localparam int AW = $clog2(HEAP_WORDS);
	localparam logic [BYTE_W-1:0] HEAP_BYTES_C = BYTE_W'(HEAP_WORDS * 4);
	localparam logic [BYTE_W-1:0] WORDS_C = BYTE_W'(HEAP_WORDS);
	localparam logic [AW-1:0] LAST_C = AW'(HEAP_WORDS - 1);

	request_t req_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] w_q;
	logic [AW-1:0] n_q;
	logic [BYTE_W-1:0] total_q;
	logic [AW-1:0] set_start_q;
	logic [BYTE_W-1:0] set_size_q;
	logic set_used_q;
	logic [AW-1:0] sp_addr_q;
	logic [AW-1:0] sp_foot_q;
	logic [BYTE_W-1:0] sp_size_q;
	result_t result_q;
	logic done_q;

	logic we;
	logic [AW-1:0] waddr;
	logic [TAG_W-1:0] wdata;
	logic [AW-1:0] raddr;
	logic [TAG_W-1:0] rdata;

	logic [BYTE_W-1:0] rsize;
	logic rfree;
	logic [BYTE_W-1:0] sum_next;
	logic [BYTE_W-1:0] rem;
	logic [BYTE_W-1:0] h_wide;
	logic [BYTE_W-1:0] total_d;
	logic [BYTE_W-1:0] sp_addr_w;
	logic [BYTE_W-1:0] foot_w;
	logic [BYTE_W-1:0] prev_start_w;
	logic [BYTE_W-1:0] set_foot_w;
	logic [BYTE_W-1:0] pay_w;

	function automatic logic blk_ok(input logic [AW-1:0] base,
			input logic [BYTE_W-1:0] size);
		return (size >= TAG_BYTES) && (size[1:0] == 2'b00)
			&& (((BYTE_W'(base)) << 2) + size <= HEAP_BYTES_C);
	endfunction

	bth_ram #(
		.WIDTH(TAG_W),
		.DEPTH(HEAP_WORDS)
	) u_heap (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rsize = {1'b0, rdata[SIZE_W-1:0]};
	assign rfree = ~rdata[ALLOC_POS];
	assign sum_next = BYTE_W'(w_q) + (rsize >> 2);
	assign rem = rsize - total_q;
	assign h_wide = BYTE_W'(req_q.block_address[11:2]) - BYTE_W'(1);
	assign total_d = (BYTE_W'(req_q.request_bytes) + BYTE_W'(15)) & ~BYTE_W'(7);
	assign sp_addr_w = BYTE_W'(w_q) + (total_q >> 2);
	assign foot_w = sum_next - BYTE_W'(1);
	assign prev_start_w = BYTE_W'(w_q) - (rsize >> 2);
	assign set_foot_w = BYTE_W'(set_start_q) + (set_size_q >> 2) - BYTE_W'(1);
	assign pay_w = (BYTE_W'(set_start_q) + BYTE_W'(1)) << 2;

	always_comb begin
		stat.clr_last = (clr_q == LAST_C);
		stat.op_free = (req_q.operation == OP_FREE);
		stat.free_bad = (req_q.block_address == 12'd0)
			|| (req_q.block_address[1:0] != 2'b00) || (h_wide >= WORDS_C);
		stat.blk_ok = blk_ok(w_q, rsize);
		stat.fits = rfree && (rsize >= total_q);
		stat.split = (rem > BYTE_W'(4));
		stat.next_end = (sum_next >= WORDS_C);
		stat.next_ok = rfree && blk_ok(n_q, rsize);
		stat.prev_ok = rfree && (rsize >= TAG_BYTES) && (rsize[1:0] == 2'b00)
			&& ((rsize >> 2) <= BYTE_W'(w_q));
		stat.h_zero = (w_q == '0);
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_ZERO: raddr = '0;
			RD_NEXT: raddr = sum_next[AW-1:0];
			RD_HDR: raddr = h_wide[AW-1:0];
			RD_PREV: raddr = w_q - AW'(1);
			default: raddr = '0;
		endcase
	end

	always_comb begin
		we = 1'b1;
		waddr = '0;
		wdata = '0;
		case (cmd.wr_sel)
			WR_NONE: begin
				we = 1'b0;
			end
			WR_CLEAR: begin
				waddr = clr_q;
				if (clr_q == '0 || clr_q == LAST_C) begin
					wdata = tag_make(HEAP_BYTES_C, 1'b0);
				end
			end
			WR_SPLIT_H: begin
				waddr = sp_addr_q;
				wdata = tag_make(sp_size_q, 1'b0);
			end
			WR_SPLIT_F: begin
				waddr = sp_foot_q;
				wdata = tag_make(sp_size_q, 1'b0);
			end
			WR_SET_H: begin
				waddr = set_start_q;
				wdata = tag_make(set_size_q, set_used_q);
			end
			WR_SET_F: begin
				waddr = set_foot_w[AW-1:0];
				wdata = tag_make(set_size_q, set_used_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.wr_sel == WR_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= request;
		end
		if (cmd.a_init) begin
			w_q <= '0;
			total_q <= total_d;
		end
		if (cmd.walk_step) begin
			w_q <= sum_next[AW-1:0];
		end
		if (cmd.load_h) begin
			w_q <= h_wide[AW-1:0];
		end
		if (cmd.fit_take) begin
			set_start_q <= w_q;
			set_used_q <= 1'b1;
			sp_addr_q <= sp_addr_w[AW-1:0];
			sp_foot_q <= foot_w[AW-1:0];
			sp_size_q <= rem;
			set_size_q <= stat.split ? total_q : rsize;
		end
		if (cmd.hdr_load) begin
			set_start_q <= w_q;
			set_size_q <= rsize;
			set_used_q <= 1'b0;
			n_q <= sum_next[AW-1:0];
		end
		if (cmd.merge_next) begin
			set_size_q <= set_size_q + rsize;
		end
		if (cmd.merge_prev) begin
			set_size_q <= set_size_q + rsize;
			set_start_q <= prev_start_w[AW-1:0];
		end
		if (cmd.finish) begin
			result_q.status <= cmd.fin_status;
			result_q.payload_address <= (cmd.fin_status == STATUS_ALLOC) ? pay_w[11:0]
				: 12'd0;
		end
	end

	assign result = result_q;
	assign done = done_q;

endmodule

// ===== rtl/boundary_tag_heap_allocator.sv =====
// Boundary-tag heap allocator with a first-fit walk over an implicit free list kept in a
// heap RAM of HEAP_WORDS words with one read port and one write port. After reset the block
// is busy while it writes the initial heap image, one word per cycle. A transaction is taken
// when start is high and busy is low. An allocate reads one block header per cycle from the
// heap RAM during its walk over the blocks. When the granted block is split, it then writes
// the header and footer of the split-off remainder, and in every case it writes the tags of
// the granted block. A free reads the header, the next neighbor and the previous neighbor,
// then does two tag writes. The result is shown for exactly one cycle with done high and
// cannot be held off by the receiver; busy drops in that same cycle, so the next transaction
// may start while the result is shown.
module boundary_tag_heap_allocator #(
	parameter int HEAP_WORDS = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input bth_pkg::request_t request,
	output bth_pkg::result_t result,
	output logic done
);

	import bth_pkg::*;

	cmd_t cmd;
	dp_status_t stat;

	bth_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.operation(request.operation),
		.stat(stat),
		.cmd(cmd),
		.busy(busy)
	);

	bth_datapath #(
		.HEAP_WORDS(HEAP_WORDS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.request(request),
		.cmd(cmd),
		.stat(stat),
		.result(result),
		.done(done)
	);

endmodule

// ===== tb/heap_tb_pkg.sv =====
`timescale 1ns / 1ps

package heap_tb_pkg;

	import bth_pkg::*;

	localparam int unsigned HEAP_WORDS = 1024;
	localparam int unsigned HEAP_BYTES = HEAP_WORDS * 4;
	localparam int unsigned TAG_OVERHEAD = 8;
	localparam bit [31:0] SIZE_MASK = 32'h1FFF_FFFF;
	localparam bit [31:0] ALLOC_FLAG = 32'h2000_0000;

	class heap_scoreboard;
		bit [31:0] words [HEAP_WORDS];
		result_t pending_results [$];
		int mismatches;

		function new();
			foreach (words[i]) words[i] = '0;
			write_block(0, HEAP_BYTES, 1'b0);
			mismatches = 0;
		endfunction

		function bit block_sane(int unsigned w, int unsigned s);
			if (s < TAG_OVERHEAD || s % 4 != 0 || w >= HEAP_WORDS) begin
				return 1'b0;
			end
			return w * 4 + s <= HEAP_BYTES;
		endfunction

		function void write_block(int unsigned w, int unsigned s, bit used);
			bit [31:0] tag;
			tag = (s & SIZE_MASK) | (used ? ALLOC_FLAG : 32'h0);
			words[w] = tag;
			words[w + s / 4 - 1] = tag;
		endfunction

		function bit first_fit(int unsigned req, output int unsigned grant);
			int unsigned total;
			int unsigned w;
			int unsigned s;
			int unsigned rem;
			bit [31:0] tag;
			total = (req + TAG_OVERHEAD + 7) & ~32'd7;
			w = 0;
			grant = 0;
			while (w < HEAP_WORDS) begin
				tag = words[w];
				s = tag & SIZE_MASK;
				if (!block_sane(w, s)) begin
					return 1'b0;
				end
				if ((tag & ALLOC_FLAG) == 0 && s >= total) begin
					rem = s - total;
					if (rem > 4) begin
						write_block(w + total / 4, rem, 1'b0);
						s = total;
					end
					write_block(w, s, 1'b1);
					grant = (w + 1) * 4;
					return 1'b1;
				end
				w += s / 4;
			end
			return 1'b0;
		endfunction

		// The previous neighbor is located through its footer, so only its free flag and its size are checked.
		function void free_payload(int unsigned addr);
			int unsigned h;
			int unsigned s;
			int unsigned first;
			int unsigned n;
			int unsigned ns;
			int unsigned ps;
			bit [31:0] tag;
			if (addr == 0 || addr % 4 != 0) begin
				return;
			end
			h = addr / 4 - 1;
			if (h >= HEAP_WORDS) begin
				return;
			end
			s = words[h] & SIZE_MASK;
			if (!block_sane(h, s)) begin
				return;
			end
			first = h;
			n = h + s / 4;
			if (n < HEAP_WORDS) begin
				tag = words[n];
				ns = tag & SIZE_MASK;
				if ((tag & ALLOC_FLAG) == 0 && block_sane(n, ns)) begin
					s += ns;
				end
			end
			if (h > 0) begin
				tag = words[h - 1];
				ps = tag & SIZE_MASK;
				if ((tag & ALLOC_FLAG) == 0 && ps >= TAG_OVERHEAD && ps % 4 == 0
						&& ps / 4 <= h) begin
					first = h - ps / 4;
					s += ps;
				end
			end
			write_block(first, s, 1'b0);
		endfunction

		function result_t note_request(request_t r);
			result_t res;
			int unsigned grant;
			if (r.operation == OP_ALLOC) begin
				if (first_fit(r.request_bytes, grant)) begin
					res.payload_address = 12'(grant);
					res.status = STATUS_ALLOC;
				end else begin
					res.payload_address = '0;
					res.status = STATUS_NOFIT;
				end
			end else begin
				free_payload(r.block_address);
				res.payload_address = '0;
				res.status = STATUS_FREED;
			end
			pending_results.push_back(res);
			return res;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result addr=%0d status=%0d",
					got.payload_address, got.status));
				return;
			end
			want = pending_results.pop_front();
			if (got.payload_address !== want.payload_address) begin
				report($sformatf("payload_address %0d, expected %0d",
					got.payload_address, want.payload_address));
			end
			if (got.status !== want.status) begin
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			end
		endtask
	endclass

endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	import bth_pkg::*;
	import heap_tb_pkg::*;

	localparam int RANDOM_ITEMS = 1150;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	request_t request;
	result_t result;

	heap_scoreboard sb;
	logic [11:0] live_blocks [$];
	logic [11:0] recent_frees [$];
	bit burst_mode;

	boundary_tag_heap_allocator #(
		.HEAP_WORDS(HEAP_WORDS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.result(result),
		.done(done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(result);
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (burst_mode) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 16);
		return $urandom_range(20, 120);
	endfunction

	function automatic int unsigned pick_size();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return $urandom_range(0, 64);
		if (roll < 95) return $urandom_range(65, 600);
		if (roll < 98) return $urandom_range(601, 4088);
		return $urandom_range(4089, 8191);
	endfunction

	task automatic send_transaction(logic op, int unsigned bytes, int unsigned addr);
		request_t r;
		result_t predicted;
		int unsigned gap;
		r.operation = op;
		r.request_bytes = (op == OP_ALLOC) ? 13'(bytes) : 13'($urandom_range(0, 8191));
		r.block_address = (op == OP_FREE) ? 12'(addr) : 12'($urandom_range(0, 4095));
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		predicted = sb.note_request(r);
		if (op == OP_ALLOC && predicted.status == STATUS_ALLOC) begin
			live_blocks.push_back(predicted.payload_address);
		end
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic alloc_block(int unsigned bytes);
		send_transaction(OP_ALLOC, bytes, 0);
	endtask

	task automatic free_block(int unsigned addr);
		send_transaction(OP_FREE, 0, addr);
		recent_frees.push_back(12'(addr));
		if (recent_frees.size() > 8) begin
			void'(recent_frees.pop_front());
		end
	endtask

	task automatic free_live();
		int unsigned idx;
		logic [11:0] addr;
		idx = $urandom_range(0, live_blocks.size() - 1);
		addr = live_blocks[idx];
		live_blocks.delete(idx);
		free_block(addr);
	endtask

	task automatic send_noise(bit chaos);
		int unsigned sel;
		sel = chaos ? $urandom_range(0, 3) : $urandom_range(0, 1);
		case (sel)
			0: begin
				free_block(0);
			end
			1: begin
				free_block({10'($urandom_range(0, 1023)), 2'($urandom_range(1, 3))});
			end
			2: begin
				free_block($urandom_range(0, 4095));
			end
			default: begin
				if (recent_frees.size() != 0) begin
					free_block(recent_frees[$urandom_range(0, recent_frees.size() - 1)]);
				end else begin
					free_block($urandom_range(0, 4095));
				end
			end
		endcase
	endtask

	initial begin
		int unsigned roll;
		int unsigned free_pct;
		bit chaos;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		burst_mode = 1'b0;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: tag rounding, splits, every merge shape, bad frees and a full heap.
		alloc_block(0);
		alloc_block(1);
		alloc_block(8);
		alloc_block(4096);
		alloc_block(8191);
		alloc_block(12);
		free_block(0);
		free_block(13);
		free_block(4095);
		free_block(12);
		free_block(12);
		free_block(28);
		free_block(4);
		free_block(44);
		alloc_block(4088);
		alloc_block(0);
		free_block(4);
		alloc_block(4080);
		alloc_block(0);
		free_block(2000);
		free_block(4092);
		free_block(4);
		live_blocks.delete();
		recent_frees.delete();

		// Random: mostly well-formed traffic, with more frequent and more corrupting frees mixed in over the last stretch.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			burst_mode = (i % 192) < 48;
			chaos = i >= RANDOM_ITEMS - RANDOM_ITEMS / 10;
			roll = $urandom_range(0, 99);
			free_pct = (live_blocks.size() > 40) ? 65 : 40;
			if (roll < (chaos ? 25 : 5)) begin
				send_noise(chaos);
			end else if (live_blocks.size() != 0 && $urandom_range(0, 99) < free_pct) begin
				free_live();
			end else begin
				alloc_block(pick_size());
			end
		end
		start <= 1'b0;

		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
